// ----- hw/rtl/jsv_pkg.sv -----
// Shared types, character codes and error codes for the JSON syntax validator.
// No dependencies; the validator top level refers to this package by scoped names.

package jsv_pkg;

    // Lexer modes, one-hot
    typedef enum logic [11:0] {
        MODE_TOP     = 12'b0000_0000_0001,
        MODE_ARR     = 12'b0000_0000_0010,
        MODE_OBJ     = 12'b0000_0000_0100,
        MODE_KEY     = 12'b0000_0000_1000,
        MODE_KEY_ESC = 12'b0000_0001_0000,
        MODE_COLON   = 12'b0000_0010_0000,
        MODE_MEMBER  = 12'b0000_0100_0000,
        MODE_STR     = 12'b0000_1000_0000,
        MODE_STR_ESC = 12'b0001_0000_0000,
        MODE_LIT     = 12'b0010_0000_0000,
        MODE_NUM     = 12'b0100_0000_0000,
        MODE_AFTER   = 12'b1000_0000_0000
    } t_mode;

    typedef logic [3:0] t_err;

    localparam t_err ERR_OK         = 4'd0;
    localparam t_err ERR_BAD_CHAR   = 4'd1;
    localparam t_err ERR_MANY_MAINS = 4'd2;
    localparam t_err ERR_OPEN_QUOTE = 4'd3;
    localparam t_err ERR_NO_COLON   = 4'd4;
    localparam t_err ERR_NO_VALUE   = 4'd5;
    localparam t_err ERR_NO_BRACKET = 4'd6;
    localparam t_err ERR_NO_BRACE   = 4'd7;
    localparam t_err ERR_BAD_TERM   = 4'd8;
    localparam t_err ERR_TWO_DOTS   = 4'd9;
    localparam t_err ERR_NO_FRAC    = 4'd10;
    localparam t_err ERR_TOO_DEEP   = 4'd11;

    // Container kinds held on the nesting stack
    localparam logic KIND_ARR = 1'b0;
    localparam logic KIND_OBJ = 1'b1;

    // Literal kinds
    localparam logic [1:0] LIT_FALSE = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Length of a literal; an unused kind code maps to false
    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            LIT_TRUE: len = 3'd4;
            LIT_NULL: len = 3'd4;
            default:  len = 3'd5;
        endcase
        return len;
    endfunction

    // Expected character of a literal at a position
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        case (kind)
            LIT_TRUE: begin
                case (pos)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = CH_NUL;
                endcase
            end
            LIT_NULL: begin
                case (pos)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = CH_NUL;
                endcase
            end
            default: begin
                case (pos)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// ----- hw/rtl/json_syntax_validator_top.sv -----
// A result is loaded into the result register as the final byte moves out of the input register;
// that byte waits in the input register while the result register still holds an unread result.
// Throughput: one document byte per cycle, set by the lexer state update, except while a final byte waits.
// Reset: synchronous, active low; clears lexer state, depth and handshake flags. The nesting
// stack memory is not cleared and needs no clearing pass.
// Top level of the JSON syntax validator; depends on jsv_pkg.

module json_syntax_validator_top #(
    parameter int MAX_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input bytes
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // last_byte
    // Results
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [3:0] error_code, [5:4] top_values, [7:6] zero
);

    // Depth counter holds 0..MAX_DEPTH; stack address covers the entries below the top
    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MEM_N = 2 ** AW;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic [3:0] r_out_err;
    logic [1:0] r_out_mains;

    logic w_adv;   // the held byte is processed this cycle
    logic w_take;  // an input item is accepted

    // A final byte needs room in the result register; other bytes always advance
    assign w_adv  = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_take = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Lexer state
    // ------------------------------------------------------------------
    jsv_pkg::t_mode r_mode, n_mode;
    logic [DW-1:0]  r_depth, n_depth;
    logic [2:0]     r_lpos, n_lpos;
    logic [1:0]     r_lkind, n_lkind;
    logic [1:0]     r_nflags, n_nflags;   // bit 0 dot seen, bit 1 digit after dot
    jsv_pkg::t_err  r_err, n_err;
    logic [1:0]     r_mains, n_mains;
    logic           r_ended, n_ended;

    // Nesting stack: r_top is the innermost kind, r_below the one under it,
    // the memory holds everything below the top
    logic           r_top;
    logic           r_below;
    logic           n_top;
    logic           mem_kind [MEM_N];

    logic           push;
    logic           push_kind;
    logic           pop;
    logic           go;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [DW-1:0]  depth_m2;
    logic [DW-1:0]  depth_m1;
    jsv_pkg::t_mode ctx_mode;
    logic [7:0]     c;

    assign c = r_in_byte;

    // Mode to return to after a value, from the container that encloses it
    always_comb begin
        if (r_depth == '0) begin
            ctx_mode = jsv_pkg::MODE_TOP;
        end else if (r_top == jsv_pkg::KIND_OBJ) begin
            ctx_mode = jsv_pkg::MODE_OBJ;
        end else begin
            ctx_mode = jsv_pkg::MODE_ARR;
        end
    end

    // One byte may pass through up to three modes: a number ends, the closer
    // is seen after it, then the enclosing container consumes the closer
    always_comb begin
        n_mode    = r_mode;
        n_depth   = r_depth;
        n_lpos    = r_lpos;
        n_lkind   = r_lkind;
        n_nflags  = r_nflags;
        n_err     = r_err;
        n_mains   = r_mains;
        n_ended   = r_ended;
        push      = 1'b0;
        push_kind = jsv_pkg::KIND_ARR;
        pop       = 1'b0;
        go        = (c != jsv_pkg::CH_NUL) && !r_ended;

        for (int i = 0; i < 3; i++) begin
            if (go && (n_err == jsv_pkg::ERR_OK)) begin
                go = 1'b0;
                case (n_mode)
                    jsv_pkg::MODE_TOP, jsv_pkg::MODE_ARR, jsv_pkg::MODE_MEMBER: begin
                        if (jsv_pkg::is_space(c)) begin
                            // skip whitespace
                        end else if ((n_mode == jsv_pkg::MODE_TOP) &&
                                     ((c == jsv_pkg::CH_RBRACK) || (c == jsv_pkg::CH_RBRACE))) begin
                            n_err = jsv_pkg::ERR_BAD_TERM;
                        end else if ((n_mode == jsv_pkg::MODE_ARR) &&
                                     (c == jsv_pkg::CH_RBRACK)) begin
                            pop     = 1'b1;
                            n_depth = (n_depth != '0) ? n_depth - 1'b1 : n_depth;
                            n_mode  = jsv_pkg::MODE_AFTER;
                        end else if ((n_mode == jsv_pkg::MODE_ARR) &&
                                     (c == jsv_pkg::CH_RBRACE)) begin
                            n_err = jsv_pkg::ERR_BAD_TERM;
                        end else begin
                            // Count a top-level value, then start the value
                            if ((n_mode == jsv_pkg::MODE_TOP) && (n_mains < 2'd2)) begin
                                n_mains = n_mains + 2'd1;
                            end
                            if ((c == jsv_pkg::CH_LBRACE) || (c == jsv_pkg::CH_LBRACK)) begin
                                if (n_depth >= DW'(MAX_DEPTH)) begin
                                    n_err = jsv_pkg::ERR_TOO_DEEP;
                                end else begin
                                    push      = 1'b1;
                                    push_kind = (c == jsv_pkg::CH_LBRACE) ?
                                                jsv_pkg::KIND_OBJ : jsv_pkg::KIND_ARR;
                                    n_depth   = n_depth + 1'b1;
                                    n_mode    = (c == jsv_pkg::CH_LBRACE) ?
                                                jsv_pkg::MODE_OBJ : jsv_pkg::MODE_ARR;
                                end
                            end else if (c == jsv_pkg::CH_QUOTE) begin
                                n_mode = jsv_pkg::MODE_STR;
                            end else if ((c == jsv_pkg::CH_LOW_F) || (c == jsv_pkg::CH_LOW_T) ||
                                         (c == jsv_pkg::CH_LOW_N)) begin
                                n_lkind = (c == jsv_pkg::CH_LOW_F) ? jsv_pkg::LIT_FALSE :
                                          (c == jsv_pkg::CH_LOW_T) ? jsv_pkg::LIT_TRUE :
                                                                     jsv_pkg::LIT_NULL;
                                n_lpos  = 3'd1;
                                n_mode  = jsv_pkg::MODE_LIT;
                            end else if (jsv_pkg::is_digit(c)) begin
                                n_nflags = 2'b00;
                                n_mode   = jsv_pkg::MODE_NUM;
                            end else if ((c == jsv_pkg::CH_RBRACK) ||
                                         (c == jsv_pkg::CH_RBRACE)) begin
                                n_err = jsv_pkg::ERR_NO_VALUE;
                            end else begin
                                n_err = jsv_pkg::ERR_BAD_CHAR;
                            end
                        end
                    end
                    jsv_pkg::MODE_OBJ: begin
                        if (jsv_pkg::is_space(c)) begin
                            // skip whitespace
                        end else if (c == jsv_pkg::CH_RBRACE) begin
                            pop     = 1'b1;
                            n_depth = (n_depth != '0) ? n_depth - 1'b1 : n_depth;
                            n_mode  = jsv_pkg::MODE_AFTER;
                        end else if (c == jsv_pkg::CH_QUOTE) begin
                            n_mode = jsv_pkg::MODE_KEY;
                        end else begin
                            n_err = jsv_pkg::ERR_BAD_CHAR;
                        end
                    end
                    jsv_pkg::MODE_KEY: begin
                        if (c == jsv_pkg::CH_BSLASH) begin
                            n_mode = jsv_pkg::MODE_KEY_ESC;
                        end else if (c == jsv_pkg::CH_QUOTE) begin
                            n_mode = jsv_pkg::MODE_COLON;
                        end
                    end
                    jsv_pkg::MODE_KEY_ESC: begin
                        n_mode = jsv_pkg::MODE_KEY;
                    end
                    jsv_pkg::MODE_COLON: begin
                        if (c == jsv_pkg::CH_COLON) begin
                            n_mode = jsv_pkg::MODE_MEMBER;
                        end else if (!jsv_pkg::is_space(c)) begin
                            n_err = jsv_pkg::ERR_BAD_CHAR;
                        end
                    end
                    jsv_pkg::MODE_STR: begin
                        if (c == jsv_pkg::CH_BSLASH) begin
                            n_mode = jsv_pkg::MODE_STR_ESC;
                        end else if (c == jsv_pkg::CH_QUOTE) begin
                            n_mode = jsv_pkg::MODE_AFTER;
                        end
                    end
                    jsv_pkg::MODE_STR_ESC: begin
                        n_mode = jsv_pkg::MODE_STR;
                    end
                    jsv_pkg::MODE_LIT: begin
                        if ((n_lpos < jsv_pkg::lit_len(n_lkind)) &&
                            (c == jsv_pkg::lit_char(n_lkind, n_lpos))) begin
                            n_lpos = n_lpos + 3'd1;
                            if (n_lpos >= jsv_pkg::lit_len(n_lkind)) begin
                                n_mode = jsv_pkg::MODE_AFTER;
                            end
                        end else begin
                            n_err = jsv_pkg::ERR_BAD_CHAR;
                        end
                    end
                    jsv_pkg::MODE_NUM: begin
                        if (jsv_pkg::is_digit(c)) begin
                            if (n_nflags[0]) begin
                                n_nflags[1] = 1'b1;
                            end
                        end else if (c == jsv_pkg::CH_DOT) begin
                            if (n_nflags[0]) begin
                                n_err = jsv_pkg::ERR_TWO_DOTS;
                            end else begin
                                n_nflags[0] = 1'b1;
                            end
                        end else begin
                            // Number ends; hand the byte on to the after-value mode
                            if (n_nflags[0] && !n_nflags[1]) begin
                                n_err = jsv_pkg::ERR_NO_FRAC;
                            end
                            n_mode = jsv_pkg::MODE_AFTER;
                            go     = 1'b1;
                        end
                    end
                    jsv_pkg::MODE_AFTER: begin
                        if (jsv_pkg::is_space(c)) begin
                            // skip whitespace
                        end else if (c == jsv_pkg::CH_COMMA) begin
                            n_mode = ctx_mode;
                        end else if ((c == jsv_pkg::CH_RBRACK) || (c == jsv_pkg::CH_RBRACE)) begin
                            // Let the enclosing container see the closer
                            n_mode = ctx_mode;
                            go     = 1'b1;
                        end else begin
                            n_err = jsv_pkg::ERR_BAD_TERM;
                        end
                    end
                    default: begin
                        n_mode = ctx_mode;
                        go     = 1'b1;
                    end
                endcase
            end
        end

        // Innermost kind after this byte's push or pop
        n_top = push ? push_kind : (pop ? r_below : r_top);

        // End of text: a NUL byte, or the final byte when no NUL came first
        if (!r_ended && ((c == jsv_pkg::CH_NUL) || r_in_last)) begin
            n_ended = 1'b1;
            if (n_err == jsv_pkg::ERR_OK) begin
                case (n_mode)
                    jsv_pkg::MODE_STR, jsv_pkg::MODE_STR_ESC,
                    jsv_pkg::MODE_KEY, jsv_pkg::MODE_KEY_ESC: begin
                        n_err = jsv_pkg::ERR_OPEN_QUOTE;
                    end
                    jsv_pkg::MODE_LIT: begin
                        n_err = jsv_pkg::ERR_BAD_CHAR;
                    end
                    jsv_pkg::MODE_NUM: begin
                        if (n_nflags[0] && !n_nflags[1]) begin
                            n_err = jsv_pkg::ERR_NO_FRAC;
                        end
                    end
                    jsv_pkg::MODE_COLON: begin
                        n_err = jsv_pkg::ERR_NO_COLON;
                    end
                    default: begin
                    end
                endcase
                if ((n_err == jsv_pkg::ERR_OK) && (n_depth != '0)) begin
                    n_err = (n_top == jsv_pkg::KIND_OBJ) ?
                            jsv_pkg::ERR_NO_BRACE : jsv_pkg::ERR_NO_BRACKET;
                end
                if ((n_err == jsv_pkg::ERR_OK) && (n_mains > 2'd1)) begin
                    n_err = jsv_pkg::ERR_MANY_MAINS;
                end
            end
        end
    end

    // Advance the lexer; return to the reset state after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= jsv_pkg::MODE_TOP;
            r_depth  <= '0;
            r_lpos   <= 3'd0;
            r_lkind  <= jsv_pkg::LIT_FALSE;
            r_nflags <= 2'b00;
            r_err    <= jsv_pkg::ERR_OK;
            r_mains  <= 2'd0;
            r_ended  <= 1'b0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_mode   <= jsv_pkg::MODE_TOP;
                r_depth  <= '0;
                r_lpos   <= 3'd0;
                r_lkind  <= jsv_pkg::LIT_FALSE;
                r_nflags <= 2'b00;
                r_err    <= jsv_pkg::ERR_OK;
                r_mains  <= 2'd0;
                r_ended  <= 1'b0;
            end else begin
                r_mode   <= n_mode;
                r_depth  <= n_depth;
                r_lpos   <= n_lpos;
                r_lkind  <= n_lkind;
                r_nflags <= n_nflags;
                r_err    <= n_err;
                r_mains  <= n_mains;
                r_ended  <= n_ended;
            end
        end
    end

    // ------------------------------------------------------------------
    // Nesting stack memory
    // ------------------------------------------------------------------
    assign depth_m1 = r_depth - 1'b1;
    assign depth_m2 = n_depth - DW'(2);
    assign wr_addr  = depth_m1[AW-1:0];
    assign rd_addr  = depth_m2[AW-1:0];

    // On a push, spill the old top into memory; keep r_below one entry under the top
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (push && (r_depth != '0)) begin
                mem_kind[wr_addr] <= r_top;
            end
            r_top   <= n_top;
            r_below <= push ? r_top : mem_kind[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_err   <= n_err;
            r_out_mains <= n_mains;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_mains, r_out_err};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH))
        else $error("nesting depth beyond MAX_DEPTH");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != jsv_pkg::ERR_OK) && !(w_adv && r_in_last) |=> r_err == $past(r_err))
        else $error("latched error changed inside a document");

    a_doc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last |=> (r_depth == '0) && (r_mode == jsv_pkg::MODE_TOP) &&
                               (r_err == jsv_pkg::ERR_OK) && !r_ended)
        else $error("state not returned to start after a result");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last |-> !r_out_valid || i_m_axis_tready)
        else $error("result register overwritten while holding a result");

endmodule
